>>> hdl/bmpd_pkg.sv
package bmpd_pkg;

  localparam int HDR_BYTES = 54;

  localparam logic [7:0] CHAR_B = 8'h42;
  localparam logic [7:0] CHAR_M = 8'h4d;

  localparam logic [15:0] BITS_24 = 16'd24;
  localparam logic [15:0] BITS_32 = 16'd32;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SHORT     = 3'd1;
  localparam logic [2:0] ERR_NO_MARK   = 3'd2;
  localparam logic [2:0] ERR_FILE_SIZE = 3'd3;
  localparam logic [2:0] ERR_INFO_SIZE = 3'd4;
  localparam logic [2:0] ERR_BIT_COUNT = 3'd5;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd6;
  localparam logic [2:0] ERR_TRUNCATED = 3'd7;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [23:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        has_alpha;
    logic        last;
  } res_t;

  // one decoded input item: one or two results
  typedef struct packed {
    logic valid;
    logic two;
    res_t r0;
    res_t r1;
  } push_t;

  function automatic res_t make_error(input logic [2:0] code);
    res_t r;
    r = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    r.last       = 1'b1;
    return r;
  endfunction

endpackage

>>> hdl/bmp_stream_decoder.sv
// Streaming decoder for uncompressed 24- and 32-bit bitmap files. Feed the file one
// byte per item; start_of_file (s_tuser) on the first byte restarts parsing and samples
// the buffer length, end_of_buffer (s_tlast) marks the last byte supplied. After the
// 54-byte header one header-accepted or error result comes out, then one pixel result
// per completed pixel with a bottom-up row flip in pixel_index; an early end of buffer
// adds a truncation error. The block takes one byte every clock while s_tready is high;
// each result passes the input register and then the result queue. A byte that ends the
// buffer can give two results, which leave one after the other through a four-entry
// result queue; input stalls only when that queue backs up behind a stalled output.
module bmp_stream_decoder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // byte_value, total_size
  input  logic        s_tuser,   // start_of_file
  input  logic        s_tlast,   // end_of_buffer
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // error_code, pixel_index, red, green, blue, alpha,
                                 // image_width, image_height, has_alpha, zero pad
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast    // last
);

  logic                       in_accept;
  logic                       busy;
  bmpd_pkg::push_t            push;
  logic [bmpd_pkg::CNT_W-1:0] fifo_count;
  bmpd_pkg::res_t             res;

  // room for the item in the input register plus the new one
  assign s_tready  = ({1'b0, fifo_count} + {{bmpd_pkg::CNT_W{1'b0}}, busy})
                     < (bmpd_pkg::CNT_W + 1)'(bmpd_pkg::FIFO_DEPTH);
  assign in_accept = s_tvalid && s_tready;

  bmpd_parse #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parse (
    .clk           (clk),
    .rst           (rst),
    .in_accept     (in_accept),
    .byte_value    (s_tdata[7:0]),
    .start_of_file (s_tuser),
    .end_of_buffer (s_tlast),
    .total_size    (s_tdata[39:8]),
    .busy          (busy),
    .push          (push)
  );

  bmpd_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .count     (fifo_count),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {2'b00, res.has_alpha, res.image_height, res.image_width, res.alpha,
                    res.blue, res.green, res.red, res.pixel_index, res.error_code};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= bmpd_pkg::CNT_W'(bmpd_pkg::FIFO_DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> fifo_count < bmpd_pkg::CNT_W'(bmpd_pkg::FIFO_DEPTH))
    else $error("result pushed into a full queue");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == bmpd_pkg::KIND_ERROR) |-> m_tlast)
    else $error("error result not marked last");

endmodule

>>> hdl/bmpd_parse.sv
module bmpd_parse #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_accept,
  input  logic [7:0]            byte_value,
  input  logic                  start_of_file,
  input  logic                  end_of_buffer,
  input  logic [31:0]           total_size,
  output logic                  busy,
  output bmpd_pkg::push_t       push
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [5:0]  HDR_LAST = 6'(bmpd_pkg::HDR_BYTES - 1);
  localparam logic [31:0] HDR_LEN  = 32'(bmpd_pkg::HDR_BYTES);

  // input register
  logic        stg_valid;
  logic [7:0]  stg_byte;
  logic        stg_sof;
  logic        stg_eob;
  logic [31:0] stg_total;

  // parser state
  logic [1:0]  phase, phase_next;
  logic [5:0]  hdr_cnt, hdr_cnt_next;
  logic [31:0] buf_len, buf_len_next;
  logic        mark_ok, mark_ok_next;
  logic [31:0] decl_fsize, decl_fsize_next;
  logic [31:0] decl_isize, decl_isize_next;
  logic [31:0] width_f, width_f_next;
  logic [31:0] height_f, height_f_next;
  logic [15:0] bits_f, bits_f_next;
  logic [23:0] partial, partial_next;
  logic [1:0]  bip, bip_next;
  logic [12:0] column, column_next;
  logic [12:0] rows_left, rows_left_next;
  logic [23:0] waddr, waddr_next;

  // effective values after a start of file
  logic [1:0]  e_phase;
  logic [5:0]  e_cnt;
  logic [1:0]  lane;
  logic [12:0] w13, h13;
  logic [25:0] base_prod;
  logic [23:0] pp;
  logic [7:0]  alpha_v;
  logic [1:0]  bip_last;
  logic [12:0] col_inc;
  logic        pix_last;
  logic        pix_out;
  bmpd_pkg::res_t hdr_res;

  assign busy = stg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      phase     <= PH_IDLE;
    end else begin
      stg_valid <= in_accept;
      phase     <= phase_next;
    end
    if (in_accept) begin
      stg_byte  <= byte_value;
      stg_sof   <= start_of_file;
      stg_eob   <= end_of_buffer;
      stg_total <= total_size;
    end
    hdr_cnt    <= hdr_cnt_next;
    buf_len    <= buf_len_next;
    mark_ok    <= mark_ok_next;
    decl_fsize <= decl_fsize_next;
    decl_isize <= decl_isize_next;
    width_f    <= width_f_next;
    height_f   <= height_f_next;
    bits_f     <= bits_f_next;
    partial    <= partial_next;
    bip        <= bip_next;
    column     <= column_next;
    rows_left  <= rows_left_next;
    waddr      <= waddr_next;
  end

  assign w13       = width_f[12:0];
  assign h13       = height_f[12:0];
  assign base_prod = (h13 - 13'd1) * w13;

  always_comb begin
    phase_next      = phase;
    hdr_cnt_next    = hdr_cnt;
    buf_len_next    = buf_len;
    mark_ok_next    = mark_ok;
    decl_fsize_next = decl_fsize;
    decl_isize_next = decl_isize;
    width_f_next    = width_f;
    height_f_next   = height_f;
    bits_f_next     = bits_f;
    partial_next    = partial;
    bip_next        = bip;
    column_next     = column;
    rows_left_next  = rows_left;
    waddr_next      = waddr;
    push            = '0;
    e_phase         = phase;
    e_cnt           = hdr_cnt;
    lane            = '0;
    pp              = partial;
    alpha_v         = 8'd0;
    bip_last        = (bits_f == bmpd_pkg::BITS_32) ? 2'd3 : 2'd2;
    col_inc         = column + 13'd1;
    pix_last        = 1'b0;
    pix_out         = 1'b0;
    hdr_res         = '0;

    if (stg_valid) begin
      if (stg_sof) begin
        e_phase         = PH_HEADER;
        e_cnt           = 6'd0;
        buf_len_next    = stg_total;
        decl_fsize_next = '0;
        decl_isize_next = '0;
        width_f_next    = '0;
        height_f_next   = '0;
        bits_f_next     = '0;
      end
      phase_next = e_phase;

      case (e_phase)
        PH_HEADER: begin
          hdr_cnt_next = e_cnt + 6'd1;
          // every four-byte field starts two bytes after a multiple of four
          lane = e_cnt[1:0] - 2'd2;
          if (e_cnt == 6'd0) begin
            mark_ok_next = (stg_byte == bmpd_pkg::CHAR_B);
          end else if (e_cnt == 6'd1) begin
            mark_ok_next = mark_ok && (stg_byte == bmpd_pkg::CHAR_M);
          end else if (e_cnt >= 6'd2 && e_cnt < 6'd6) begin
            decl_fsize_next[{lane, 3'b000} +: 8] = stg_byte;
          end else if (e_cnt >= 6'd14 && e_cnt < 6'd18) begin
            decl_isize_next[{lane, 3'b000} +: 8] = stg_byte;
          end else if (e_cnt >= 6'd18 && e_cnt < 6'd22) begin
            width_f_next[{lane, 3'b000} +: 8] = stg_byte;
          end else if (e_cnt >= 6'd22 && e_cnt < 6'd26) begin
            height_f_next[{lane, 3'b000} +: 8] = stg_byte;
          end else if (e_cnt >= 6'd28 && e_cnt < 6'd30) begin
            bits_f_next[{lane[0], 3'b000} +: 8] = stg_byte;
          end

          if (e_cnt == HDR_LAST) begin
            push.valid = 1'b1;
            phase_next = PH_DONE;
            if (buf_len < HDR_LEN) begin
              push.r0 = bmpd_pkg::make_error(bmpd_pkg::ERR_SHORT);
            end else if (!mark_ok) begin
              push.r0 = bmpd_pkg::make_error(bmpd_pkg::ERR_NO_MARK);
            end else if (decl_fsize > buf_len) begin
              push.r0 = bmpd_pkg::make_error(bmpd_pkg::ERR_FILE_SIZE);
            end else if (decl_isize > buf_len - HDR_LEN) begin
              push.r0 = bmpd_pkg::make_error(bmpd_pkg::ERR_INFO_SIZE);
            end else if (bits_f != bmpd_pkg::BITS_24 && bits_f != bmpd_pkg::BITS_32) begin
              push.r0 = bmpd_pkg::make_error(bmpd_pkg::ERR_BIT_COUNT);
            end else if (width_f > 32'(MAX_WIDTH) || height_f > 32'(MAX_HEIGHT)) begin
              push.r0 = bmpd_pkg::make_error(bmpd_pkg::ERR_TOO_LARGE);
            end else begin
              hdr_res.kind         = bmpd_pkg::KIND_HEADER;
              hdr_res.error_code   = bmpd_pkg::ERR_NONE;
              hdr_res.image_width  = w13;
              hdr_res.image_height = h13;
              hdr_res.has_alpha    = (bits_f == bmpd_pkg::BITS_32);
              hdr_res.last         = (width_f == '0) || (height_f == '0);
              push.r0              = hdr_res;
              if (!hdr_res.last) begin
                phase_next     = PH_PIXELS;
                column_next    = '0;
                rows_left_next = h13;
                bip_next       = '0;
                partial_next   = '0;
                waddr_next     = base_prod[23:0];
                if (stg_eob) begin
                  push.two = 1'b1;
                  push.r1  = bmpd_pkg::make_error(bmpd_pkg::ERR_TRUNCATED);
                end
              end
            end
          end else if (stg_eob) begin
            push.valid = 1'b1;
            push.r0    = bmpd_pkg::make_error((buf_len_next < HDR_LEN) ?
                                              bmpd_pkg::ERR_SHORT :
                                              bmpd_pkg::ERR_TRUNCATED);
          end
        end

        PH_PIXELS: begin
          case (bip)
            2'd0:    pp[7:0]   = stg_byte;
            2'd1:    pp[15:8]  = stg_byte;
            2'd2:    pp[23:16] = stg_byte;
            default: alpha_v   = stg_byte;
          endcase
          if (bip != bip_last) begin
            bip_next     = bip + 2'd1;
            partial_next = pp;
          end else begin
            pix_out  = 1'b1;
            pix_last = (rows_left == 13'd1) && (col_inc == w13);
            push.valid          = 1'b1;
            push.r0             = '0;
            push.r0.kind        = bmpd_pkg::KIND_PIXEL;
            push.r0.pixel_index = waddr;
            push.r0.red         = pp[23:16];
            push.r0.green       = pp[15:8];
            push.r0.blue        = pp[7:0];
            push.r0.alpha       = alpha_v;
            push.r0.last        = pix_last;
            bip_next            = '0;
            partial_next        = '0;
            // end of a stored row steps back up one display row
            if (col_inc >= w13) begin
              column_next    = '0;
              rows_left_next = rows_left - 13'd1;
              waddr_next     = waddr + 24'd1 - {10'd0, w13, 1'b0};
            end else begin
              column_next = col_inc;
              waddr_next  = waddr + 24'd1;
            end
            if (pix_last) begin
              phase_next = PH_DONE;
            end
          end
          if (stg_eob && !pix_last) begin
            push.valid = 1'b1;
            if (pix_out) begin
              push.two = 1'b1;
              push.r1  = bmpd_pkg::make_error(bmpd_pkg::ERR_TRUNCATED);
            end else begin
              push.r0 = bmpd_pkg::make_error(bmpd_pkg::ERR_TRUNCATED);
            end
          end
        end

        default: begin
        end
      endcase

      if (stg_eob && e_phase != PH_IDLE) begin
        phase_next = PH_DONE;
      end
    end
  end

endmodule

>>> hdl/bmpd_out_fifo.sv
module bmpd_out_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  bmpd_pkg::push_t               push,
  output logic [bmpd_pkg::CNT_W-1:0]    count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bmpd_pkg::res_t                out_res
);

  bmpd_pkg::res_t mem_r0 [bmpd_pkg::FIFO_DEPTH];
  bmpd_pkg::res_t mem_r1 [bmpd_pkg::FIFO_DEPTH];
  logic           mem_two [bmpd_pkg::FIFO_DEPTH];

  logic [bmpd_pkg::PTR_W-1:0] wr_ptr;
  logic [bmpd_pkg::PTR_W-1:0] rd_ptr;
  logic                       sub;
  logic                       take;
  logic                       pop;

  function automatic logic [bmpd_pkg::CNT_W-1:0] CNT_ONE(input logic b);
    return {{(bmpd_pkg::CNT_W-1){1'b0}}, b};
  endfunction

  assign out_valid = (count != '0);
  assign out_res   = sub ? mem_r1[rd_ptr] : mem_r0[rd_ptr];
  assign take      = out_valid && out_ready;
  // an entry leaves after its second result, or its only one
  assign pop       = take && (sub || !mem_two[rd_ptr]);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sub    <= 1'b0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
        sub    <= 1'b0;
      end else if (take) begin
        sub <= 1'b1;
      end
      count <= count + CNT_ONE(push.valid) - CNT_ONE(pop);
    end
    if (push.valid) begin
      mem_r0[wr_ptr]  <= push.r0;
      mem_r1[wr_ptr]  <= push.r1;
      mem_two[wr_ptr] <= push.two;
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import bmpd_pkg::*;

  localparam int MAX_W       = 4096;
  localparam int MAX_H       = 4096;
  localparam int ITEM_TARGET = 2000;
  localparam int SINK_HOLD   = 300;
  localparam int QUIET_LIMIT = 4000;

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_PIXELS, PH_DONE} phase_e;

  class frame_checker;
    phase_e      phase;
    logic [5:0]  hdr_count;
    logic [31:0] buf_len;
    logic        mark_ok;
    logic [31:0] decl_fsize;
    logic [31:0] decl_isize;
    logic [31:0] width_f;
    logic [31:0] height_f;
    logic [15:0] bits_f;
    logic [23:0] pix_acc;
    logic [1:0]  pix_byte;
    logic [12:0] col;
    logic [12:0] rows_left;
    logic [23:0] dest_addr;
    res_t        expected_results[$];
    int          failures;

    function new();
      failures = 0;
      clear();
    endfunction

    function void clear();
      phase      = PH_IDLE;
      hdr_count  = '0;
      buf_len    = '0;
      mark_ok    = 1'b0;
      decl_fsize = '0;
      decl_isize = '0;
      width_f    = '0;
      height_f   = '0;
      bits_f     = '0;
      pix_acc    = '0;
      pix_byte   = '0;
      col        = '0;
      rows_left  = '0;
      dest_addr  = '0;
    endfunction

    function void push_error(logic [2:0] code);
      res_t r;
      r            = '0;
      r.kind       = KIND_ERROR;
      r.error_code = code;
      r.last       = 1'b1;
      expected_results.push_back(r);
      phase = PH_DONE;
    endfunction

    // little-endian header fields, all start at zero
    function void gather(int p, logic [7:0] v);
      if (p == 0) mark_ok = (v == CHAR_B);
      else if (p == 1) mark_ok = mark_ok && (v == CHAR_M);
      else if (p >= 2 && p < 6) decl_fsize[8*(p-2) +: 8] = v;
      else if (p >= 14 && p < 18) decl_isize[8*(p-14) +: 8] = v;
      else if (p >= 18 && p < 22) width_f[8*(p-18) +: 8] = v;
      else if (p >= 22 && p < 26) height_f[8*(p-22) +: 8] = v;
      else if (p >= 28 && p < 30) bits_f[8*(p-28) +: 8] = v;
    endfunction

    function void close_header();
      res_t        r;
      logic [31:0] room;
      logic [31:0] first_row;
      room = buf_len - 32'(HDR_BYTES);
      if (buf_len < 32'(HDR_BYTES)) push_error(ERR_SHORT);
      else if (!mark_ok) push_error(ERR_NO_MARK);
      else if (decl_fsize > buf_len) push_error(ERR_FILE_SIZE);
      else if (decl_isize > room) push_error(ERR_INFO_SIZE);
      else if (bits_f != BITS_24 && bits_f != BITS_32) push_error(ERR_BIT_COUNT);
      else if (width_f > 32'(MAX_W) || height_f > 32'(MAX_H)) push_error(ERR_TOO_LARGE);
      else begin
        r              = '0;
        r.kind         = KIND_HEADER;
        r.image_width  = width_f[12:0];
        r.image_height = height_f[12:0];
        r.has_alpha    = (bits_f == BITS_32);
        r.last         = (width_f == 0) || (height_f == 0);
        expected_results.push_back(r);
        if (r.last) begin
          phase = PH_DONE;
        end else begin
          phase     = PH_PIXELS;
          col       = '0;
          rows_left = height_f[12:0];
          pix_byte  = '0;
          pix_acc   = '0;
          // rows are stored bottom-up, so writing starts at the last row
          first_row = (height_f - 1) * width_f;
          dest_addr = first_row[23:0];
        end
      end
    endfunction

    function void pixel_step(logic [7:0] v);
      res_t       r;
      logic [7:0] a;
      int         bpp;
      bpp = (bits_f == BITS_32) ? 4 : 3;
      a   = '0;
      if (pix_byte < 2'd3) pix_acc[8*pix_byte +: 8] = v;
      else a = v;
      if (int'(pix_byte) + 1 < bpp) begin
        pix_byte = pix_byte + 2'd1;
        return;
      end
      r             = '0;
      r.kind        = KIND_PIXEL;
      r.pixel_index = dest_addr;
      r.red         = pix_acc[23:16];
      r.green       = pix_acc[15:8];
      r.blue        = pix_acc[7:0];
      r.alpha       = a;
      r.last        = (rows_left == 13'd1) && (32'(col) + 1 == width_f);
      expected_results.push_back(r);
      pix_byte  = '0;
      pix_acc   = '0;
      dest_addr = dest_addr + 24'd1;
      col       = col + 13'd1;
      if (32'(col) >= width_f) begin
        col       = '0;
        rows_left = rows_left - 13'd1;
        dest_addr = dest_addr - 24'(2 * width_f);
      end
      if (r.last) phase = PH_DONE;
    endfunction

    function void take_byte(logic [7:0] v, logic sof, logic eob, logic [31:0] total);
      if (sof) begin
        clear();
        buf_len = total;
        phase   = PH_HEADER;
      end
      if (phase == PH_HEADER) begin
        gather(int'(hdr_count), v);
        hdr_count = hdr_count + 6'd1;
        if (hdr_count >= 6'(HDR_BYTES)) begin
          close_header();
          if (eob && phase == PH_PIXELS) push_error(ERR_TRUNCATED);
        end else if (eob) begin
          push_error(buf_len < 32'(HDR_BYTES) ? ERR_SHORT : ERR_TRUNCATED);
        end
      end else if (phase == PH_PIXELS) begin
        pixel_step(v);
        if (eob && phase == PH_PIXELS) push_error(ERR_TRUNCATED);
      end
      if (eob && phase != PH_IDLE) phase = PH_DONE;
    endfunction

    function void same(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [1:0] kind, logic last, logic [87:0] d);
      res_t w;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: kind %0d", kind);
        failures++;
        return;
      end
      w = expected_results.pop_front();
      same("kind", 32'(w.kind), 32'(kind));
      same("error_code", 32'(w.error_code), 32'(d[2:0]));
      same("pixel_index", 32'(w.pixel_index), 32'(d[26:3]));
      same("red", 32'(w.red), 32'(d[34:27]));
      same("green", 32'(w.green), 32'(d[42:35]));
      same("blue", 32'(w.blue), 32'(d[50:43]));
      same("alpha", 32'(w.alpha), 32'(d[58:51]));
      same("image_width", 32'(w.image_width), 32'(d[71:59]));
      same("image_height", 32'(w.image_height), 32'(d[84:72]));
      same("has_alpha", 32'(w.has_alpha), 32'(d[85]));
      same("last", 32'(w.last), 32'(last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  frame_checker sb;
  logic [7:0]   hdr_buf [HDR_BYTES];
  bit           idle_mode;
  bit           sink_steady;
  bit           hold_sink;
  int           items_sent;
  int           quiet_cycles;

  bmp_stream_decoder #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.take_byte(s_tdata[7:0], s_tuser, s_tlast, s_tdata[39:8]);
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tlast, m_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $error("no progress, %0d results still expected", sb.expected_results.size());
      $display("FAIL bmp_stream_decoder");
      $finish;
    end
  end

  function automatic int send_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int stall_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: ready stretches, short and long stalls, one long hold-off on request
  initial begin : sink
    @(posedge clk);
    forever begin
      if (hold_sink) begin
        hold_sink = 1'b0;
        m_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
      end else if (sink_steady || $urandom_range(0, 3) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat (stall_len()) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic sof, input logic eob,
                           input logic [31:0] total);
    int gap;
    gap = send_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    // the length field only counts with start_of_file, otherwise it is noise
    s_tdata  <= {sof ? total : 32'($urandom), b};
    s_tuser  <= sof;
    s_tlast  <= eob;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic void put_le(int at, int n, logic [31:0] val);
    for (int k = 0; k < n; k++) hdr_buf[at + k] = val[8*k +: 8];
  endfunction

  function automatic void make_header(logic [31:0] fsize, logic [31:0] isize,
                                      logic [31:0] w, logic [31:0] h, logic [15:0] bits);
    for (int i = 0; i < HDR_BYTES; i++) hdr_buf[i] = 8'($urandom);
    hdr_buf[0] = CHAR_B;
    hdr_buf[1] = CHAR_M;
    put_le(2, 4, fsize);
    put_le(14, 4, isize);
    put_le(18, 4, w);
    put_le(22, 4, h);
    put_le(28, 2, 32'(bits));
  endfunction

  // header from hdr_buf, then pixel bytes (random or a fixed fill)
  task automatic send_file(input logic [31:0] total, input int n_send, input bit with_eob,
                           input int fill);
    logic [7:0] b;
    for (int i = 0; i < n_send; i++) begin
      if (i < HDR_BYTES) b = hdr_buf[i];
      else if (fill < 0) b = 8'($urandom);
      else b = 8'(fill);
      send_item(b, i == 0, with_eob && (i == n_send - 1), total);
    end
  endtask

  task automatic send_image(input int w, input int h, input logic [15:0] bits,
                            input int cut, input bit with_eob, input int fill);
    int          full;
    logic [31:0] total;
    full  = HDR_BYTES + w * h * ((bits == BITS_32) ? 4 : 3);
    total = full + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0);
    make_header($urandom_range(0, total), $urandom_range(0, total - HDR_BYTES), w, h, bits);
    send_file(total, (cut < 0) ? full : cut, with_eob, fill);
  endtask

  task automatic send_bad_header();
    logic [31:0] total;
    logic [31:0] fsize;
    logic [31:0] isize;
    logic [31:0] w;
    logic [31:0] h;
    logic [15:0] bits;
    int          flaw;
    total = ($urandom_range(0, 1) != 0) ? $urandom_range(HDR_BYTES, 300)
                                        : $urandom_range(HDR_BYTES, 32'hFFFF_FFF0);
    fsize = $urandom_range(0, total);
    isize = $urandom_range(0, total - HDR_BYTES);
    w     = $urandom_range(0, 4);
    h     = $urandom_range(0, 4);
    bits  = ($urandom_range(0, 1) != 0) ? BITS_32 : BITS_24;
    flaw  = $urandom_range(0, 5);
    case (flaw)
      0: total = $urandom_range(0, HDR_BYTES - 1);
      2: fsize = total + $urandom_range(1, 15);
      3: isize = total - HDR_BYTES + $urandom_range(1, 15);
      4: do bits = 16'($urandom); while (bits == BITS_24 || bits == BITS_32);
      5: begin
        if ($urandom_range(0, 1) != 0) w = $urandom_range(MAX_W + 1, 32'hFFFF_FFFF);
        else h = $urandom_range(MAX_H + 1, 32'hFFFF_FFFF);
      end
      default: ;
    endcase
    make_header(fsize, isize, w, h, bits);
    if (flaw == 1) hdr_buf[$urandom_range(0, 1)] = 8'($urandom);
    send_file(total, HDR_BYTES + $urandom_range(0, 8), $urandom_range(0, 1) != 0, -1);
  endtask

  initial begin : stim
    int          pick;
    int          w;
    int          h;
    logic [15:0] bits;
    sb        = new();
    idle_mode = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // stray bytes before any file
    repeat (3) send_item(8'($urandom), 1'b0, 1'b0, '0);
    send_image(2, 2, BITS_24, -1, 1, 0);
    send_image(3, 2, BITS_32, -1, 1, 255);
    // empty images give a header marked last
    send_image(0, 3, BITS_24, -1, 1, -1);
    send_image(4, 0, BITS_32, -1, 0, -1);
    // bytes after a finished file are ignored
    repeat (4) send_item(8'($urandom), 1'b0, $urandom_range(0, 1) != 0, '0);
    // buffer shorter than a header
    make_header(0, 0, 1, 1, BITS_24);
    send_file(1, 1, 1, -1);
    send_file(20, 20, 1, -1);
    send_file(10, HDR_BYTES + 3, 0, -1);
    // buffer ends inside the header
    send_file(200, 30, 1, -1);
    send_file(32'hFFFF_FFFF, 1, 1, -1);
    // broken mark
    make_header(60, 0, 1, 1, BITS_24);
    hdr_buf[0] = 8'h41;
    send_file(60, 57, 1, -1);
    hdr_buf[0] = CHAR_B;
    hdr_buf[1] = 8'h4e;
    send_file(60, 60, 1, -1);
    // declared sizes beyond the buffer
    make_header(61, 0, 1, 1, BITS_24);
    send_file(60, 57, 1, -1);
    make_header(60, 7, 2, 1, BITS_24);
    send_file(60, 60, 1, -1);
    // unsupported bit counts
    make_header(57, 0, 1, 1, 16'd16);
    send_file(57, 57, 1, -1);
    make_header(57, 0, 1, 1, 16'h0118);
    send_file(57, 57, 1, -1);
    // too wide, and a negative height
    make_header(57, 0, MAX_W + 1, 1, BITS_24);
    send_file(57, 57, 1, -1);
    make_header(58, 0, 1, 32'hFFFF_FFFF, BITS_32);
    send_file(58, 58, 1, -1);
    // end of buffer on the last header byte with pixels still due
    send_image(2, 2, BITS_24, HDR_BYTES, 1, -1);
    // end of buffer on a completed pixel that is not the last
    send_image(2, 2, BITS_32, HDR_BYTES + 8, 1, -1);
    // end of buffer inside a pixel
    send_image(3, 1, BITS_24, HDR_BYTES + 4, 1, -1);
    // restart in the middle of a file
    send_image(2, 3, BITS_24, HDR_BYTES + 5, 0, -1);
    send_image(1, 1, BITS_24, -1, 1, -1);
    make_header(66, 12, 2, 2, BITS_24);
    send_file(32'hFFFF_FFFF, 66, 1, -1);
    wait_drained();

    // start of the widest image sent back to back while the receiver holds off
    idle_mode = 1'b0;
    hold_sink = 1'b1;
    send_image(MAX_W, 1, BITS_32, HDR_BYTES + 4 * 24, 1, -1);
    wait_drained();
    idle_mode = 1'b1;
    send_image(1, MAX_H, BITS_24, HDR_BYTES + 3 * 8, 1, -1);
    send_image(MAX_W, MAX_H, BITS_24, HDR_BYTES + 3 * 10, 1, -1);
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      idle_mode   = ($urandom_range(0, 4) != 0);
      sink_steady = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 99);
      w    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 5);
      h    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 4);
      bits = ($urandom_range(0, 1) != 0) ? BITS_32 : BITS_24;
      if (pick < 65) begin
        send_image(w, h, bits, -1, $urandom_range(0, 9) != 0, -1);
      end else if (pick < 80) begin
        send_image(w, h, bits, $urandom_range(1, HDR_BYTES + w * h * 4),
                   $urandom_range(0, 1) != 0, -1);
      end else if (pick < 93) begin
        send_bad_header();
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(8'($urandom), 1'b0, $urandom_range(0, 3) == 0, $urandom);
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    sink_steady = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.expected_results.size() == 0) begin
      $display("PASS bmp_stream_decoder");
    end else begin
      $display("FAIL bmp_stream_decoder");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/bmpd_pkg.sv
hdl/bmpd_parse.sv
hdl/bmpd_out_fifo.sv
hdl/bmp_stream_decoder.sv
tb/tb.sv
